FILE: rtl/sdsce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdsce_pkg
// Shared types, constants and functions for the SD SPI command engine.
// ----------------------------------------------------------------------------
package sdsce_pkg;

    localparam logic [7:0]  BYTE_IDLE      = 8'hFF;
    localparam logic [7:0]  CRC_POLY_SHL   = 8'h12;
    localparam logic [1:0]  FRAME_START    = 2'b01;
    localparam logic [15:0] POLL_LIMIT_RST = 16'd100;
    localparam logic [2:0]  IGNORE_INIT    = 3'd7;

    localparam logic        CMD_START      = 1'b0;
    localparam logic        CMD_XCHG       = 1'b1;

    localparam logic [1:0]  FMT_R1         = 2'd0;
    localparam logic [1:0]  FMT_R1B        = 2'd1;
    localparam logic [1:0]  FMT_R2         = 2'd2;
    localparam logic [1:0]  FMT_R3         = 2'd3;

    localparam logic        ST_OK          = 1'b0;
    localparam logic        ST_TIMEOUT     = 1'b1;

    localparam logic [2:0]  FRM_PRE_IDX    = 3'd0;
    localparam logic [2:0]  FRM_SEL_IDX    = 3'd1;
    localparam logic [2:0]  FRM_FIRST_IDX  = 3'd2;
    localparam logic [2:0]  FRM_LAST_IDX   = 3'd6;
    localparam logic [2:0]  FRM_CRC_IDX    = 3'd7;

    localparam logic [2:0]  FIN_SEL_IDX    = 3'd0;
    localparam logic [2:0]  FIN_DESEL_IDX  = 3'd1;
    localparam logic [2:0]  FIN_STAT_IDX   = 3'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_POLL,
        PH_RESP,
        PH_BUSY
    } t_phase;

    typedef enum logic [1:0] {
        TAIL_FRAME,
        TAIL_POLL,
        TAIL_FINISH
    } t_tail;

    typedef enum logic [1:0] {
        KIND_TX,
        KIND_RESP,
        KIND_DONE
    } t_kind;

    typedef struct packed {
        logic        valid;
        logic        has_resp;
        logic [7:0]  resp_byte;
        logic [2:0]  resp_pos;
        t_tail       tail;
        logic        status;
        logic [39:0] frame;
    } t_run;

    function automatic logic [2:0] resp_len(input logic [1:0] fmt);
        logic [2:0] len;
        case (fmt)
            FMT_R1:  len = 3'd1;
            FMT_R1B: len = 3'd1;
            FMT_R2:  len = 3'd2;
            FMT_R3:  len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int j = 0; j < 8; j++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY_SHL;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sdsce_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdsce_ctrl
// Command phase tracking: decides the result run for each transaction.
// ----------------------------------------------------------------------------
module sdsce_ctrl
    import sdsce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic        i_cmd,
    input  wire logic [5:0]  i_command_index,
    input  wire logic [31:0] i_argument,
    input  wire logic [1:0]  i_response_format,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    output t_run             o_run
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_ignore, n_ignore;
    logic [15:0] r_poll, n_poll;
    logic [2:0]  r_rem, n_rem;
    logic        r_busy_pend, n_busy_pend;
    logic [2:0]  r_ridx, n_ridx;
    logic [15:0] r_poll_limit;

    logic [15:0] w_poll_inc;
    logic        w_timeout;
    logic        w_hit;
    logic [2:0]  w_rem_dec;

    assign w_poll_inc = r_poll + 16'd1;
    assign w_timeout  = (w_poll_inc >= r_poll_limit);
    assign w_hit      = ~i_rx_byte[7];
    assign w_rem_dec  = (r_rem != 3'd0) ? (r_rem - 3'd1) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_ignore     <= '0;
            r_poll       <= '0;
            r_rem        <= '0;
            r_busy_pend  <= 1'b0;
            r_ridx       <= '0;
            r_poll_limit <= POLL_LIMIT_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_poll_limit <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_phase     <= n_phase;
                r_ignore    <= n_ignore;
                r_poll      <= n_poll;
                r_rem       <= n_rem;
                r_busy_pend <= n_busy_pend;
                r_ridx      <= n_ridx;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_cmd == CMD_START) begin
            n_phase = PH_SEND;
        end else begin
            unique case (r_phase)
                PH_SEND: begin
                    if (r_ignore == 3'd0) n_phase = PH_POLL;
                end
                PH_POLL: begin
                    if (w_timeout) begin
                        n_phase = PH_IDLE;
                    end else if (w_hit) begin
                        if (r_rem > 3'd1)    n_phase = PH_RESP;
                        else if (r_busy_pend) n_phase = PH_BUSY;
                        else                  n_phase = PH_IDLE;
                    end
                end
                PH_RESP: begin
                    if (w_rem_dec != 3'd0) n_phase = PH_RESP;
                    else if (r_busy_pend)  n_phase = PH_BUSY;
                    else                   n_phase = PH_IDLE;
                end
                PH_BUSY: begin
                    if (i_rx_byte != 8'd0) n_phase = PH_IDLE;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // counters and result run
    always_comb begin
        n_ignore    = r_ignore;
        n_poll      = r_poll;
        n_rem       = r_rem;
        n_busy_pend = r_busy_pend;
        n_ridx      = r_ridx;
        o_run           = '0;
        o_run.tail      = TAIL_POLL;
        o_run.status    = ST_OK;
        o_run.frame     = {FRAME_START, i_command_index, i_argument};
        o_run.resp_byte = i_rx_byte;
        if (i_cmd == CMD_START) begin
            o_run.valid = 1'b1;
            o_run.tail  = TAIL_FRAME;
            n_ignore    = IGNORE_INIT;
            n_poll      = '0;
            n_rem       = resp_len(i_response_format);
            n_busy_pend = (i_response_format == FMT_R1B);
            n_ridx      = '0;
        end else begin
            unique case (r_phase)
                PH_SEND: begin
                    if (r_ignore != 3'd0) begin
                        n_ignore = r_ignore - 3'd1;
                    end else begin
                        o_run.valid = 1'b1;
                        n_poll      = '0;
                    end
                end
                PH_POLL: begin
                    n_poll      = w_poll_inc;
                    o_run.valid = 1'b1;
                    if (w_timeout) begin
                        o_run.tail   = TAIL_FINISH;
                        o_run.status = ST_TIMEOUT;
                    end else if (w_hit) begin
                        o_run.has_resp = 1'b1;
                        n_ridx         = 3'd1;
                        if (r_rem > 3'd1) begin
                            n_rem = r_rem - 3'd1;
                        end else begin
                            n_rem = '0;
                            if (!r_busy_pend) o_run.tail = TAIL_FINISH;
                        end
                    end
                end
                PH_RESP: begin
                    o_run.valid    = 1'b1;
                    o_run.has_resp = 1'b1;
                    o_run.resp_pos = r_ridx;
                    n_ridx         = r_ridx + 3'd1;
                    n_rem          = w_rem_dec;
                    if (w_rem_dec == 3'd0 && !r_busy_pend) o_run.tail = TAIL_FINISH;
                end
                PH_BUSY: begin
                    o_run.valid = 1'b1;
                    if (i_rx_byte != 8'd0) o_run.tail = TAIL_FINISH;
                end
                default: begin
                end
            endcase
        end
    end

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd == CMD_START) |=> (r_phase == PH_SEND && r_ignore == IGNORE_INIT))
        else $error("start did not load send phase");

    a_send_to_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd == CMD_XCHG && r_phase == PH_SEND && r_ignore == 3'd0)
        |=> (r_phase == PH_POLL && r_poll == 16'd0))
        else $error("send phase did not hand over to polling");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_XCHG && r_phase == PH_IDLE) |-> !o_run.valid)
        else $error("exchange while idle produced a result");

endmodule
`default_nettype wire

FILE: rtl/sdsce_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdsce_emit
// Result run register and serialiser: one result per output transaction.
// ----------------------------------------------------------------------------
module sdsce_emit
    import sdsce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_run        i_run,
    output logic             o_ready,
    output logic             o_tvalid,
    input  wire logic        i_tready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_chip_select,
    output logic [7:0]       o_resp_byte,
    output logic [2:0]       o_resp_pos,
    output logic             o_status,
    output logic             o_last
);

    logic        r_busy;
    logic        r_has_resp;
    logic [7:0]  r_resp_byte;
    logic [2:0]  r_resp_pos;
    t_tail       r_tail;
    logic        r_status;
    logic [39:0] r_frame;
    logic [7:0]  r_crc;
    logic [2:0]  r_idx;

    logic w_fire;
    logic w_frame_byte;

    assign o_tvalid     = r_busy;
    assign w_fire       = r_busy && i_tready;
    assign o_ready      = !r_busy || (i_tready && o_last);
    assign w_frame_byte = !r_has_resp && r_tail == TAIL_FRAME &&
                          r_idx >= FRM_FIRST_IDX && r_idx <= FRM_LAST_IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load && i_run.valid) begin
            r_busy <= 1'b1;
        end else if (w_fire && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_run.valid) begin
            r_has_resp  <= i_run.has_resp;
            r_resp_byte <= i_run.resp_byte;
            r_resp_pos  <= i_run.resp_pos;
            r_tail      <= i_run.tail;
            r_status    <= i_run.status;
            r_frame     <= i_run.frame;
            r_crc       <= '0;
            r_idx       <= '0;
        end else if (w_fire) begin
            if (r_has_resp) begin
                r_has_resp <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
                if (w_frame_byte) begin
                    r_frame <= {r_frame[31:0], 8'd0};
                    r_crc   <= crc7_byte(r_crc, r_frame[39:32]);
                end
            end
        end
    end

    always_comb begin
        o_kind        = KIND_TX;
        o_tx_byte     = '0;
        o_chip_select = 1'b0;
        o_resp_byte   = '0;
        o_resp_pos    = '0;
        o_status      = ST_OK;
        o_last        = 1'b0;
        if (r_has_resp) begin
            o_kind      = KIND_RESP;
            o_resp_byte = r_resp_byte;
            o_resp_pos  = r_resp_pos;
        end else begin
            case (r_tail)
                TAIL_FRAME: begin
                    o_chip_select = (r_idx != FRM_PRE_IDX);
                    if (r_idx == FRM_PRE_IDX || r_idx == FRM_SEL_IDX) begin
                        o_tx_byte = BYTE_IDLE;
                    end else if (r_idx == FRM_CRC_IDX) begin
                        o_tx_byte = r_crc | 8'h01;
                        o_last    = 1'b1;
                    end else begin
                        o_tx_byte = r_frame[39:32];
                    end
                end
                TAIL_POLL: begin
                    o_tx_byte     = BYTE_IDLE;
                    o_chip_select = 1'b1;
                    o_last        = 1'b1;
                end
                TAIL_FINISH: begin
                    if (r_idx == FIN_SEL_IDX) begin
                        o_tx_byte     = BYTE_IDLE;
                        o_chip_select = 1'b1;
                    end else if (r_idx == FIN_DESEL_IDX) begin
                        o_tx_byte = BYTE_IDLE;
                    end else begin
                        o_kind   = KIND_DONE;
                        o_status = r_status;
                        o_last   = 1'b1;
                    end
                end
                default: begin
                    o_last = 1'b1;
                end
            endcase
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_run.valid) |=> o_tvalid)
        else $error("loaded run not presented");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && o_last && !(i_load && i_run.valid)) |=> !o_tvalid)
        else $error("run continued past its last result");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_busy) |-> (i_tready && o_last))
        else $error("run overwritten before it drained");

endmodule
`default_nettype wire

FILE: rtl/sd_spi_command_engine_top.sv
// The first result of a transaction is registered and appears in the cycle after acceptance.
// Throughput: a transaction that yields N results holds the output until all N are taken (one
// result per cycle while the output is ready, at most eight); the next input transaction is taken
// in the cycle the last result is taken, so single-result items flow one per cycle when not stalled.
// Reset: synchronous, active low; returns to idle with poll limit 100.
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_command_engine_top
// SD card SPI-mode command engine with CRC7 framing and response collection.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_top
    import sdsce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // command_index, argument, response_format, rx_byte
    input  wire logic        i_s_axis_tuser,  // cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // tx_byte, chip_select, resp_byte, resp_position, status
    output logic [1:0]       o_m_axis_tuser,  // kind
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    t_run       w_run;
    logic       w_fire;
    logic [7:0] w_tx_byte;
    logic       w_cs;
    logic [7:0] w_resp_byte;
    logic [2:0] w_resp_pos;
    logic       w_status;

    assign w_fire = i_s_axis_tvalid && o_s_axis_tready;

    sdsce_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_fire),
        .i_cmd             (i_s_axis_tuser),
        .i_command_index   (i_s_axis_tdata[5:0]),
        .i_argument        (i_s_axis_tdata[37:6]),
        .i_response_format (i_s_axis_tdata[39:38]),
        .i_rx_byte         (i_s_axis_tdata[47:40]),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_run             (w_run)
    );

    sdsce_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_fire),
        .i_run         (w_run),
        .o_ready       (o_s_axis_tready),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_kind        (o_m_axis_tuser),
        .o_tx_byte     (w_tx_byte),
        .o_chip_select (w_cs),
        .o_resp_byte   (w_resp_byte),
        .o_resp_pos    (w_resp_pos),
        .o_status      (w_status),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'd0, w_status, w_resp_pos, w_resp_byte, w_cs, w_tx_byte};

endmodule
`default_nettype wire
